>>> rtl/page_framebuffer_glyph_and_bar_plotter_unit_assert.svh
// Assertion macros for the page frame store plotter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef PAGE_FRAMEBUFFER_GLYPH_AND_BAR_PLOTTER_UNIT_ASSERT_SVH
`define PAGE_FRAMEBUFFER_GLYPH_AND_BAR_PLOTTER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PFB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pfb_pkg.sv
// Shared types, constants and the 5x7 font table for the page frame store plotter.
// No dependencies.
package pfb_pkg;

	// Default geometry
	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;

	// Drawing constants
	localparam logic [7:0] GLYPH_FIRST  = 8'h20;
	localparam logic [7:0] GLYPH_LAST   = 8'h5F;
	localparam logic [7:0] GLYPH_COLS   = 8'd5;
	localparam logic [6:0] BAR_FILL     = 7'h7F;
	localparam logic [6:0] BAR_OUTLINE  = 7'h41;
	localparam logic [6:0] BAR_FULL_PCT = 7'd100;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_GLYPH = 2'd1,
		OP_BAR   = 2'd2,
		OP_READ  = 2'd3
	} pfb_op_t;

	// Request to the byte merge unit
	typedef struct packed {
		logic [6:0] pattern;
		logic [2:0] shift;
		logic       upper;
		logic [5:0] page;
	} pfb_merge_req_t;

	// Font: one entry per code 0x20..0x5F, column 0 in the top byte
	localparam logic [39:0] FONT_ROM [64] = '{
		40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
		40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
		40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
		40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
		40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
		40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
		40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
		40'h00_08_14_22_41, 40'h14_14_14_14_14, 40'h41_22_14_08_00, 40'h02_01_51_09_06,
		40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
		40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_01_01, 40'h3E_41_41_51_32,
		40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
		40'h7F_40_40_40_40, 40'h7F_02_04_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
		40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
		40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F,
		40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h61_51_49_45_43, 40'h00_00_00_00_00,
		40'h02_04_08_10_20, 40'h00_00_00_00_00, 40'h00_02_01_02_00, 40'h40_40_40_40_40
	};

	// One 7-row column of a glyph
	function automatic logic [6:0] font_column(input logic [5:0] idx, input logic [2:0] col);
		logic [39:0] entry;
		entry = FONT_ROM[idx];
		case (col)
			3'd0:    return entry[38:32];
			3'd1:    return entry[30:24];
			3'd2:    return entry[22:16];
			3'd3:    return entry[14:8];
			3'd4:    return entry[6:0];
			default: return 7'd0;
		endcase
	endfunction

endpackage

>>> rtl/pfb_if.sv
// Valid/ready channel interfaces for the plotter command and read response.
// No dependencies.
interface pfb_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] x;
	logic [7:0] y;
	logic [7:0] glyph;
	logic [7:0] bar_width;
	logic [7:0] bar_value;
	logic [9:0] read_address;

	modport source(output valid, op, x, y, glyph, bar_width, bar_value, read_address,
		input ready);
	modport sink(input valid, op, x, y, glyph, bar_width, bar_value, read_address,
		output ready);
endinterface

interface pfb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source(output valid, read_data, input ready);
	modport sink(input valid, read_data, output ready);
endinterface

>>> rtl/pfb_store.sv
// Frame store: one write port, one read port with registered read data.
// Depends on nothing.
module pfb_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/pfb_merge.sv
// Byte merge unit: shifts a 7-row column into one page byte, clips rows, ORs it in.
// Depends on pfb_pkg.
module pfb_merge import pfb_pkg::*; #(
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  pfb_merge_req_t req,
	input  logic [7:0]     old_byte,
	output logic [7:0]     new_byte
);

	logic [14:0] wide;
	logic [7:0]  part;
	logic [7:0]  row_mask;

	// Place the pattern at its row offset and pick the page half
	always_comb begin
		wide = 15'(req.pattern) << req.shift;
		part = req.upper ? {1'b0, wide[14:8]} : wide[7:0];
	end

	// Drop rows below the bottom of the screen
	always_comb begin
		for (int n = 0; n < 8; n++) begin
			row_mask[n] = (int'({req.page, 3'(n)}) < SCREEN_HEIGHT);
		end
	end

	assign new_byte = old_byte | (part & row_mask);

endmodule

>>> rtl/page_framebuffer_glyph_and_bar_plotter_unit.sv
// Channel | Dir | Payload                                          | Transaction
// cmd     | in  | op, x, y, glyph, bar_width, bar_value, read_addr | one operation
// rsp     | out | read_data                                        | one byte, read op only
//
// Glyph and bar write per drawn column one page byte at row offset zero within the page, else
// two; a bar walks bar_width columns, stopping at the right edge. Each byte goes through the
// store's single read-modify-write path through the merge unit.
// Reset: a clearing pass writes zero to every store byte; cmd.ready stays low until it ends.
// A read result waits in the rsp register; the next command is taken meanwhile, and a further
// read holds in its last cycle until rsp drains.
// Depends on pfb_pkg, pfb_if, pfb_store, pfb_merge and the assertion macro header.
`include "page_framebuffer_glyph_and_bar_plotter_unit_assert.svh"

module page_framebuffer_glyph_and_bar_plotter_unit import pfb_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input logic       clk,
	input logic       arst_n,
	pfb_cmd_if.sink   cmd,
	pfb_rsp_if.source rsp
);

	localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int AFW         = AW + 9;
	localparam logic [AW-1:0] CLR_LAST = AW'(STORE_BYTES - 1);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_COL   = 6'b000100,
		S_BYTE  = 6'b001000,
		S_WR    = 6'b010000,
		S_RDOUT = 6'b100000
	} pfb_state_t;

	// Control state
	pfb_state_t    state_q;
	logic [AW-1:0] clr_q;
	logic          rsp_valid_q;

	// Operation context
	pfb_op_t       op_q;
	logic [7:0]    x_q;
	logic [4:0]    page0_q;
	logic [2:0]    sh_q;
	logic [5:0]    gidx_q;
	logic [7:0]    count_q;
	logic [14:0]   prod_q;
	logic [14:0]   acc_q;
	logic [7:0]    col_q;
	logic          half_q;
	logic [6:0]    pat_q;
	logic [AW-1:0] waddr_q;
	logic          rd_ok_q;
	logic [7:0]    rsp_data_q;

	// Datapath signals
	logic           cmd_acc;
	pfb_op_t        cmd_op;
	logic [6:0]     val_clamp;
	logic [8:0]     px;
	logic           col_done;
	logic [6:0]     col_pat;
	logic [5:0]     page;
	logic           byte_ok;
	logic [AFW-1:0] addr_full;
	logic [AW-1:0]  byte_addr;
	logic           rsp_load;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic [7:0]     rd_data;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [7:0]     wr_data;
	logic [7:0]     merged;
	pfb_merge_req_t mreq;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cmd_op    = pfb_op_t'(cmd.op);
	assign val_clamp = (cmd.bar_value > 8'(BAR_FULL_PCT)) ? BAR_FULL_PCT : cmd.bar_value[6:0];

	// Column position, clip and pattern
	always_comb begin
		px       = {1'b0, x_q} + {1'b0, col_q};
		col_done = (col_q == count_q) || (int'(px) >= SCREEN_WIDTH);
		if (op_q == OP_GLYPH) begin
			col_pat = font_column(gidx_q, col_q[2:0]);
		end else begin
			col_pat = (acc_q <= prod_q) ? BAR_FILL : BAR_OUTLINE;
		end
	end

	// Target page byte of the current half
	always_comb begin
		page      = {1'b0, page0_q} + 6'(half_q);
		byte_ok   = (int'(page) < PAGES) && (!half_q || (sh_q != 3'd0));
		addr_full = AFW'(page) * AFW'(SCREEN_WIDTH) + AFW'(px);
		byte_addr = addr_full[AW-1:0];
	end

	// Store port control
	always_comb begin
		rd_en   = (cmd_acc && (cmd_op == OP_READ)) || ((state_q == S_BYTE) && byte_ok);
		rd_addr = (state_q == S_IDLE) ? AW'(cmd.read_address) : byte_addr;
		wr_en   = (state_q == S_CLEAR) || (state_q == S_WR);
		wr_addr = (state_q == S_CLEAR) ? clr_q : waddr_q;
		wr_data = (state_q == S_CLEAR) ? 8'h00 : merged;
	end

	assign mreq.pattern = pat_q;
	assign mreq.shift   = sh_q;
	assign mreq.upper   = half_q;
	assign mreq.page    = page;

	assign rsp_load = (state_q == S_RDOUT) && (!rsp_valid_q || rsp.ready);

	pfb_store #(
		.DEPTH(STORE_BYTES),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	pfb_merge #(
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_merge (
		.req     (mreq),
		.old_byte(rd_data),
		.new_byte(merged)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_acc) begin
						clr_q <= '0;
						case (cmd_op)
							OP_CLEAR: state_q <= S_CLEAR;
							OP_READ:  state_q <= S_RDOUT;
							default:  state_q <= S_COL;
						endcase
					end
				end
				S_COL: begin
					state_q <= col_done ? S_IDLE : S_BYTE;
				end
				S_BYTE: begin
					if (byte_ok) begin
						state_q <= S_WR;
					end else if (half_q) begin
						state_q <= S_COL;
					end
				end
				S_WR: begin
					state_q <= half_q ? S_COL : S_BYTE;
				end
				S_RDOUT: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operation context and result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					op_q    <= cmd_op;
					x_q     <= cmd.x;
					page0_q <= cmd.y[7:3];
					sh_q    <= cmd.y[2:0];
					if ((cmd.glyph < GLYPH_FIRST) || (cmd.glyph > GLYPH_LAST)) begin
						gidx_q <= 6'd0;
					end else begin
						gidx_q <= 6'(cmd.glyph - GLYPH_FIRST);
					end
					count_q <= (cmd_op == OP_GLYPH) ? GLYPH_COLS : cmd.bar_width;
					prod_q  <= 15'(val_clamp) * 15'(cmd.bar_width);
					acc_q   <= 15'(BAR_FULL_PCT);
					col_q   <= 8'd0;
					rd_ok_q <= (int'(cmd.read_address) < STORE_BYTES);
				end
			end
			S_COL: begin
				pat_q  <= col_pat;
				half_q <= 1'b0;
			end
			S_BYTE: begin
				if (byte_ok) begin
					waddr_q <= byte_addr;
				end else if (!half_q) begin
					half_q <= 1'b1;
				end else begin
					col_q <= col_q + 8'd1;
					acc_q <= acc_q + 15'(BAR_FULL_PCT);
				end
			end
			S_WR: begin
				if (!half_q) begin
					half_q <= 1'b1;
				end else begin
					col_q <= col_q + 8'd1;
					acc_q <= acc_q + 15'(BAR_FULL_PCT);
				end
			end
			S_RDOUT: begin
				if (rsp_load) begin
					rsp_data_q <= rd_ok_q ? rd_data : 8'h00;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_data_q;

	// Checks
	`PFB_ASSERT_NEXT(a_busy_after_cmd, cmd_acc, state_q != S_IDLE,
		"accepted command left the sequencer idle")
	`PFB_ASSERT_SAME(a_draw_only_sets, state_q == S_WR, (wr_data & rd_data) == rd_data,
		"draw cleared a pixel")
	`PFB_ASSERT_NEXT(a_clear_ends, (state_q == S_CLEAR) && (clr_q == CLR_LAST),
		state_q == S_IDLE, "clearing pass did not end at the last byte")
	`PFB_ASSERT_SAME(a_rsp_from_read, rsp_load, op_q == OP_READ,
		"response loaded for a non-read operation")

endmodule

>>> bench/page_framebuffer_glyph_and_bar_plotter_unit_tb.sv
// Testbench for the page frame store plotter: directed and random clear, glyph, bar and read
// transactions, each read checked against a local pixel-level image of the store.
// Depends on pfb_pkg, pfb_if and the page_framebuffer_glyph_and_bar_plotter_unit top level.
module page_framebuffer_glyph_and_bar_plotter_unit_tb;
	import pfb_pkg::*;

	localparam int SCR_W        = SCREEN_WIDTH_DEF;
	localparam int SCR_H        = SCREEN_HEIGHT_DEF;
	localparam int STORE_SIZE   = SCR_W * ((SCR_H + 7) / 8);
	localparam int CODE_FIRST   = 'h20;
	localparam int CODE_LAST    = 'h5F;
	localparam int PCT_MAX      = 100;
	localparam logic [6:0] FILL_PAT = 7'h7F;
	localparam logic [6:0] EDGE_PAT = 7'h41;
	localparam int RANDOM_ITEMS = 1825;
	localparam int HOLD_START   = 300;
	localparam int HOLD_LEN     = 400;
	localparam int END_SETTLE   = 1200;

	// 5x7 font, codes 0x20..0x5F, column 0 in bits 39:32
	localparam logic [39:0] GLYPH_BITMAP [64] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
		40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h0000000000,
		40'h0204081020, 40'h0000000000, 40'h0002010200, 40'h4040404040
	};

	typedef struct {
		pfb_op_t     op;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  code;
		logic [7:0]  width;
		logic [7:0]  pct;
		logic [9:0]  addr;
		int unsigned gap;
	} plot_cmd_t;

	logic clk = 1'b0;
	logic arst_n;

	pfb_cmd_if cmd_ch ();
	pfb_rsp_if rsp_ch ();

	page_framebuffer_glyph_and_bar_plotter_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	plot_cmd_t   pending_cmds [$];
	logic [7:0]  expected_bytes [$];
	logic [7:0]  frame_image [STORE_SIZE];
	plot_cmd_t   in_flight;
	bit          offer;
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned result_count;
	int unsigned fail_count;
	logic [7:0]  want_byte;
	logic        hold_active;
	logic        hold_done;
	int unsigned hold_cycles;
	int unsigned seen_results;

	// ---------------- store image ----------------

	function automatic void set_pixel(int px, int py);
		if (px < SCR_W && py < SCR_H)
			frame_image[(py / 8) * SCR_W + px] |= 8'(1 << (py % 8));
	endfunction

	function automatic void or_column(int px, int py, logic [6:0] pat);
		int r;
		for (r = 0; r < 7; r++)
			if (pat[r])
				set_pixel(px, py + r);
	endfunction

	// Update the image for one accepted transaction; a read queues its byte
	task automatic apply_plot_cmd(input plot_cmd_t c);
		int col;
		int pct;
		int fill;
		logic [39:0] bits;
		case (c.op)
			OP_CLEAR: begin
				foreach (frame_image[i])
					frame_image[i] = 8'h00;
			end
			OP_GLYPH: begin
				// codes outside the font draw as a space, i.e. nothing
				if (int'(c.code) >= CODE_FIRST && int'(c.code) <= CODE_LAST) begin
					bits = GLYPH_BITMAP[int'(c.code) - CODE_FIRST];
					for (col = 0; col < 5; col++)
						or_column(int'(c.x) + col, int'(c.y), bits[38 - 8 * col -: 7]);
				end
			end
			OP_BAR: begin
				pct = (int'(c.pct) > PCT_MAX) ? PCT_MAX : int'(c.pct);
				fill = (pct * int'(c.width)) / 100;
				for (col = 0; col < int'(c.width); col++)
					or_column(int'(c.x) + col, int'(c.y), (col < fill) ? FILL_PAT : EDGE_PAT);
			end
			default: begin
				expected_bytes.push_back((int'(c.addr) < STORE_SIZE) ? frame_image[c.addr] : 8'h00);
			end
		endcase
	endtask

	// ---------------- stimulus helpers ----------------

	task automatic add_cmd(input pfb_op_t op, input logic [7:0] x, input logic [7:0] y,
		input logic [7:0] code, input logic [7:0] width, input logic [7:0] pct,
		input logic [9:0] addr);
		plot_cmd_t c;
		c.op    = op;
		c.x     = x;
		c.y     = y;
		c.code  = code;
		c.width = width;
		c.pct   = pct;
		c.addr  = addr;
		// every fifth block of items goes back to back
		c.gap   = ((pending_cmds.size() / 120) % 5 == 3) ? 0 : $urandom_range(0, 10);
		pending_cmds.push_back(c);
	endtask

	task automatic add_read(input logic [9:0] addr);
		add_cmd(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), addr);
	endtask

	// Byte address of a pixel, or a random address when the pixel is off screen
	function automatic logic [9:0] addr_of(int col, int row);
		if (col < SCR_W && row < SCR_H)
			return 10'((row / 8) * SCR_W + col);
		return 10'($urandom_range(0, 1023));
	endfunction

	// Mostly near the visible area, now and then anywhere
	function automatic logic [7:0] pick_coord(int lim);
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom);
		return 8'($urandom_range(0, lim));
	endfunction

	// ---------------- command driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid        <= 1'b0;
			cmd_ch.op           <= OP_CLEAR;
			cmd_ch.x            <= '0;
			cmd_ch.y            <= '0;
			cmd_ch.glyph        <= '0;
			cmd_ch.bar_width    <= '0;
			cmd_ch.bar_value    <= '0;
			cmd_ch.read_address <= '0;
			gap_left = 0;
		end else begin
			offer = cmd_ch.valid;
			if (cmd_ch.valid && cmd_ch.ready) begin
				apply_plot_cmd(in_flight);
				offer = 1'b0;
				gap_left = (pending_cmds.size() > 0) ? pending_cmds[0].gap : 0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0) begin
					in_flight = pending_cmds.pop_front();
					cmd_ch.op           <= in_flight.op;
					cmd_ch.x            <= in_flight.x;
					cmd_ch.y            <= in_flight.y;
					cmd_ch.glyph        <= in_flight.code;
					cmd_ch.bar_width    <= in_flight.width;
					cmd_ch.bar_value    <= in_flight.pct;
					cmd_ch.read_address <= in_flight.addr;
					offer = 1'b1;
				end
			end
			cmd_ch.valid <= offer;
		end
	end

	// ---------------- response monitor ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_bytes.size() == 0) begin
					$error("read_data with no read pending: actual %02h", rsp_ch.read_data);
					fail_count++;
				end else begin
					want_byte = expected_bytes.pop_front();
					if (rsp_ch.read_data !== want_byte) begin
						$error("read_data mismatch: expected %02h, actual %02h",
							want_byte, rsp_ch.read_data);
						fail_count++;
					end
				end
				result_count++;
				// some stretches take results without any stall
				stall_left = ((result_count / 150) % 4 == 1) ? 0 : $urandom_range(0, 10);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !hold_active;
			end
		end
	end

	// Long receiver hold-off so the block backs up and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_active  <= 1'b0;
			hold_done    <= 1'b0;
			hold_cycles  <= 0;
			seen_results <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready)
				seen_results <= seen_results + 1;
			if (!hold_done && seen_results >= HOLD_START) begin
				if (hold_cycles == HOLD_LEN) begin
					hold_active <= 1'b0;
					hold_done   <= 1'b1;
				end else begin
					hold_active <= 1'b1;
					hold_cycles <= hold_cycles + 1;
				end
			end
		end
	end

	// ---------------- test sequence ----------------

	initial begin : stimulus
		int n;
		int roll;
		int reps;
		int k;
		int wid;
		logic [7:0] px;
		logic [7:0] py;
		logic [7:0] pw;

		arst_n = 1'b0;

		// Directed: font edges, codes outside the font, clipping, bar corners
		add_cmd(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'h3FF);
		add_cmd(OP_GLYPH, 8'd0, 8'd0, 8'h41, 8'h00, 8'h00, 10'h000);
		add_read(10'd0);
		add_read(10'd2);
		add_cmd(OP_GLYPH, 8'd10, 8'd3, 8'h5F, 8'hFF, 8'hFF, 10'h3FF);
		add_read(10'd10);
		add_read(10'd138);
		add_cmd(OP_GLYPH, 8'd20, 8'd0, 8'h20, 8'h00, 8'h00, 10'h000);
		add_cmd(OP_GLYPH, 8'd30, 8'd0, 8'h1F, 8'h00, 8'h00, 10'h000);
		add_cmd(OP_GLYPH, 8'd36, 8'd0, 8'hFF, 8'h00, 8'h00, 10'h000);
		add_read(10'd31);
		add_read(10'd38);
		add_cmd(OP_GLYPH, 8'd125, 8'd60, 8'h4D, 8'h00, 8'h00, 10'h000);
		add_cmd(OP_GLYPH, 8'd255, 8'd255, 8'h23, 8'h00, 8'h00, 10'h000);
		add_read(10'(7 * SCR_W + 125));
		add_cmd(OP_BAR, 8'd40, 8'd16, 8'h00, 8'd0, 8'd50, 10'h000);
		add_cmd(OP_BAR, 8'd40, 8'd18, 8'h00, 8'd20, 8'd0, 10'h000);
		add_read(10'(2 * SCR_W + 45));
		add_cmd(OP_BAR, 8'd0, 8'd24, 8'h00, 8'd30, 8'd100, 10'h000);
		add_cmd(OP_BAR, 8'd70, 8'd28, 8'h00, 8'd10, 8'd255, 10'h000);
		add_read(10'(4 * SCR_W + 75));
		add_cmd(OP_BAR, 8'd0, 8'd57, 8'h00, 8'd255, 8'd50, 10'h000);
		add_read(10'(7 * SCR_W + 127));
		add_read(10'd1023);
		add_read(10'(3 * SCR_W + 29));

		// Random: draws followed by reads of the bytes they touched, plus noise
		n = 0;
		while (n < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			px = pick_coord(132);
			py = pick_coord(68);
			if (roll < 2) begin
				add_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 10'($urandom));
				n++;
			end else if (roll < 30) begin
				add_cmd(OP_GLYPH, px, py,
					($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(32, 95)),
					8'($urandom), 8'($urandom), 10'($urandom));
				n++;
				reps = $urandom_range(1, 3);
				for (k = 0; k < reps; k++) begin
					add_read(addr_of(int'(px) + $urandom_range(0, 4),
						int'(py) + $urandom_range(0, 7)));
					n++;
				end
			end else if (roll < 42) begin
				pw = ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
				wid = int'(pw);
				add_cmd(OP_BAR, px, py, 8'($urandom), pw,
					($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 110)),
					10'($urandom));
				n++;
				reps = $urandom_range(1, 3);
				for (k = 0; k < reps; k++) begin
					add_read(addr_of(int'(px) + $urandom_range(0, wid),
						int'(py) + $urandom_range(0, 7)));
					n++;
				end
			end else begin
				add_read(10'($urandom_range(0, 1023)));
				n++;
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || cmd_ch.valid)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#(500_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/pfb_pkg.sv
rtl/pfb_if.sv
rtl/pfb_store.sv
rtl/pfb_merge.sv
rtl/page_framebuffer_glyph_and_bar_plotter_unit.sv
bench/page_framebuffer_glyph_and_bar_plotter_unit_tb.sv
